// ===== rtl/cwg_pkg.sv =====
// Shared types and constants for the cyclic waveform generator.
// No dependencies; imported by cyclic_waveform_generator_top.
package cwg_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ROM,
        ST_DONE
    } cwg_state_t;

    typedef enum logic [2:0] {
        MODE_PERIOD,
        MODE_SINE,
        MODE_TRI,
        MODE_SAW,
        MODE_DIRECT
    } cwg_mode_t;

    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SAW      = 3'd3;
    localparam logic [2:0] WAVE_CODE_MAX = 3'd5;

    localparam logic [7:0] SAMPLE_HIGH = 8'hFF;
    localparam logic [7:0] SAMPLE_LOW  = 8'h00;
    localparam logic [7:0] SAMPLE_BIAS = 8'h80;
    localparam logic [7:0] SAMPLE_ONE  = 8'h01;

    // Q28 fixed-point constants for building the sine table
    localparam longint unsigned Q_ONE     = 64'd1 << 28;
    localparam longint unsigned Q_TWO_PI  = 64'd1686629713;
    localparam longint unsigned Q_PI      = Q_TWO_PI >> 1;
    localparam longint unsigned Q_HALF_PI = Q_TWO_PI >> 2;

endpackage

// ===== rtl/cyclic_waveform_generator_top.sv =====
// Cyclic waveform generator: start/tick command channel, 8-bit sample out.
// Depends on cwg_pkg (state and mode types, wave codes, Q28 constants).
//
// Input beats (s_valid/s_ready) carry s_cmd, s_wave_code and s_tone_freq. A start
// beat (s_cmd = 1) with a frequency of at least 2*LOW_FREQ_HZ and a wave code of 5
// or less sets the period to the effective rate over tone_freq, clears the phase
// and starts playback if the period is nonzero; drop any other start beat. A tick
// beat (s_cmd = 0) during playback yields one sample beat on m_valid/m_ready; a
// tick while idle yields nothing. cfg_wr_en writes cfg_wr_data into sample_rate
// at once; write it only while the block is idle. A new rate affects later starts only.
// One shared restoring divider retires one quotient bit per cycle over DIV_W
// bits (25 at the default table depth). A start keeps s_ready low while the
// divider runs; the next beat is taken once the block is back in idle. A tick
// steps through prepare, divide, the registered table read and done for sine,
// through prepare, divide and done for triangle and saw, and through prepare
// and done for square and constant; m_valid is registered from done, and the
// next beat is taken when the block returns to idle. aresetn stops playback and clears
// the rate, period and phase. A stalled receiver holds the sample register; the
// next beat is still taken, and its work waits at the end until the output frees.
module cyclic_waveform_generator_top
    import cwg_pkg::*;
#(
    parameter int LOW_FREQ_HZ      = 110,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [2:0]  s_wave_code,
    input  logic [15:0] s_tone_freq,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_sample
);

    // Table address width and dividend width: the sine index i*DEPTH needs
    // 16 + AW bits, the triangle numerator up to 255.5*N needs 24 bits.
    localparam int AW    = $clog2(SINE_TABLE_DEPTH);
    localparam int DIV_W = (16 + AW > 25) ? 16 + AW : 25;
    localparam int CW    = $clog2(DIV_W + 1);
    localparam int SW    = DIV_W + 2;

    localparam logic [15:0]         MIN_FREQ = 16'(2 * LOW_FREQ_HZ);
    localparam logic [DIV_W-1:0]    DEPTH_K  = DIV_W'(SINE_TABLE_DEPTH);
    localparam logic signed [SW-1:0] K510    = SW'(510);
    localparam logic signed [SW-1:0] K255    = SW'(255);

    // Sine table entry: floor(128 + 127*sin(2*pi*p/DEPTH)), Q28 Taylor series
    // with quadrant folding. Evaluated at elaboration only.
    function automatic logic [7:0] sine_entry(input int unsigned p);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        logic            neg;
        neg = 1'b0;
        x = (longint'(p) * Q_TWO_PI) / SINE_TABLE_DEPTH;
        if (x > Q_PI) begin
            neg = 1'b1;
            x   = x - Q_PI;
        end
        if (x > Q_HALF_PI) begin
            x = (x > Q_PI) ? 64'd0 : Q_PI - x;
        end
        x2 = (x * x) >> 28;
        t  = Q_ONE;
        t  = Q_ONE - ((x2 * t) >> 28) / 110;
        t  = Q_ONE - ((x2 * t) >> 28) / 72;
        t  = Q_ONE - ((x2 * t) >> 28) / 42;
        t  = Q_ONE - ((x2 * t) >> 28) / 20;
        t  = Q_ONE - ((x2 * t) >> 28) / 6;
        s  = (x * t) >> 28;
        if (s > Q_ONE) begin
            s = Q_ONE;
        end
        v = neg ? (128 * Q_ONE - 127 * s) : (128 * Q_ONE + 127 * s);
        v = v >> 28;
        return (v > 64'd255) ? 8'hFF : v[7:0];
    endfunction

    // Constant sine table
    logic [7:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine_rom
        localparam logic [7:0] ENTRY = sine_entry(g);
        assign sine_rom[g] = ENTRY;
    end

    // Control and payload registers
    cwg_state_t       state_reg,       state_next;
    cwg_mode_t        mode_reg,        mode_next;
    logic [15:0]      sample_rate_reg, sample_rate_next;
    logic [15:0]      period_reg,      period_next;
    logic [15:0]      phase_reg,       phase_next;
    logic [2:0]       wave_sel_reg,    wave_sel_next;
    logic             playing_reg,     playing_next;
    logic [15:0]      cur_i_reg,       cur_i_next;
    logic [15:0]      rem_reg,         rem_next;
    logic [DIV_W-1:0] quo_reg,         quo_next;
    logic [15:0]      dvsr_reg,        dvsr_next;
    logic [CW-1:0]    cnt_reg,         cnt_next;
    logic [7:0]       res_reg,         res_next;
    logic             m_valid_reg,     m_valid_next;
    logic [7:0]       m_sample_reg,    m_sample_next;
    logic [7:0]       rom_data_reg;

    // Divider step: shift one dividend bit into the remainder, subtract
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             trial_ge;
    logic [15:0]      rem_step;
    logic [DIV_W-1:0] quo_step;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dvsr_reg};
    assign trial_ge = (trial >= {1'b0, dvsr_reg});
    assign rem_step = trial_ge ? diff[15:0] : trial[15:0];
    assign quo_step = {quo_reg[DIV_W-2:0], trial_ge};

    // Start checks and phase advance
    logic        start_ok;
    logic [15:0] eff_rate;
    logic [15:0] tick_i;
    logic [16:0] tick_i_inc;

    assign start_ok   = (s_tone_freq >= MIN_FREQ) && (s_wave_code <= WAVE_CODE_MAX);
    assign eff_rate   = (sample_rate_reg > MIN_FREQ) ? sample_rate_reg : 16'd0;
    assign tick_i     = (phase_reg >= period_reg) ? 16'd0 : phase_reg;
    assign tick_i_inc = {1'b0, tick_i} + 17'd1;

    // Dividends for the waveforms, from the latched phase and period
    logic [DIV_W-1:0]       sine_dvnd;
    logic [DIV_W-1:0]       saw_dvnd;
    logic [DIV_W-1:0]       tri_dvnd;
    logic [17:0]            i_x4;
    logic [17:0]            n_x3;
    logic signed [SW-1:0]   i_s;
    logic signed [SW-1:0]   n_s;
    logic signed [SW-1:0]   tri_d;
    logic signed [SW-1:0]   tri_num;

    assign sine_dvnd = DIV_W'(cur_i_reg) * DEPTH_K;
    assign saw_dvnd  = (DIV_W'(cur_i_reg) << 8) - DIV_W'(cur_i_reg);
    assign i_x4      = {cur_i_reg, 2'b00};
    assign n_x3      = {2'b00, period_reg} + {1'b0, period_reg, 1'b0};
    assign i_s       = signed'(SW'(cur_i_reg));
    assign n_s       = signed'(SW'(period_reg));

    // Rise, fall, rise: the numerator stays positive and its quotient
    // stays within 0..255 for any phase below the period.
    always_comb begin
        priority if (i_x4 <= {2'b00, period_reg}) begin
            tri_d = K510 * i_s;
        end else if (i_x4 < n_x3) begin
            tri_d = K255 * (n_s - (i_s <<< 1));
        end else begin
            tri_d = K510 * (i_s - n_s);
        end
    end

    assign tri_num  = (n_s <<< 7) + tri_d;
    assign tri_dvnd = tri_num[DIV_W-1:0];

    // Next state and datapath
    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        sample_rate_next = sample_rate_reg;
        period_next      = period_reg;
        phase_next       = phase_reg;
        wave_sel_next    = wave_sel_reg;
        playing_next     = playing_reg;
        cur_i_next       = cur_i_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        dvsr_next        = dvsr_reg;
        cnt_next         = cnt_reg;
        res_next         = res_reg;
        m_valid_next     = m_valid_reg;
        m_sample_next    = m_sample_reg;
        s_ready          = 1'b0;

        if (cfg_wr_en) begin
            sample_rate_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd) begin
                        if (start_ok) begin
                            // Latch the tone, then divide rate by frequency
                            wave_sel_next = s_wave_code;
                            phase_next    = 16'd0;
                            quo_next      = DIV_W'(eff_rate);
                            rem_next      = 16'd0;
                            dvsr_next     = s_tone_freq;
                            cnt_next      = CW'(DIV_W);
                            mode_next     = MODE_PERIOD;
                            state_next    = ST_DIV;
                        end
                    end else if (playing_reg) begin
                        // Take this phase, advance modulo the period
                        cur_i_next = tick_i;
                        phase_next = (tick_i_inc >= {1'b0, period_reg}) ? 16'd0
                                                                        : tick_i_inc[15:0];
                        state_next = ST_PREP;
                    end
                end
            end

            ST_PREP: begin
                rem_next  = 16'd0;
                dvsr_next = period_reg;
                cnt_next  = CW'(DIV_W);
                unique case (wave_sel_reg)
                    WAVE_SINE: begin
                        quo_next   = sine_dvnd;
                        mode_next  = MODE_SINE;
                        state_next = ST_DIV;
                    end
                    WAVE_SQUARE: begin
                        res_next   = (cur_i_reg < (period_reg >> 1)) ? SAMPLE_HIGH
                                                                     : SAMPLE_LOW;
                        mode_next  = MODE_DIRECT;
                        state_next = ST_DONE;
                    end
                    WAVE_TRIANGLE: begin
                        quo_next   = tri_dvnd;
                        mode_next  = MODE_TRI;
                        state_next = ST_DIV;
                    end
                    WAVE_SAW: begin
                        quo_next   = saw_dvnd;
                        mode_next  = MODE_SAW;
                        state_next = ST_DIV;
                    end
                    default: begin
                        res_next   = SAMPLE_ONE;
                        mode_next  = MODE_DIRECT;
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DIV: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    unique case (mode_reg)
                        MODE_PERIOD: begin
                            period_next  = quo_step[15:0];
                            playing_next = (quo_step[15:0] != 16'd0);
                            state_next   = ST_IDLE;
                        end
                        MODE_SINE: begin
                            state_next = ST_ROM;
                        end
                        MODE_TRI: begin
                            res_next   = quo_step[7:0];
                            state_next = ST_DONE;
                        end
                        MODE_SAW: begin
                            res_next   = quo_step[7:0] + SAMPLE_BIAS;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ROM: begin
                // Table read lands in rom_data_reg at the end of this cycle
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = (mode_reg == MODE_SINE) ? rom_data_reg : res_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Registered table read, addressed by the divider quotient
    always_ff @(posedge aclk) begin
        rom_data_reg <= sine_rom[quo_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sample_rate_reg <= 16'd0;
            period_reg      <= 16'd0;
            phase_reg       <= 16'd0;
            wave_sel_reg    <= WAVE_SINE;
            playing_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            mode_reg        <= MODE_PERIOD;
            cnt_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            sample_rate_reg <= sample_rate_next;
            period_reg      <= period_next;
            phase_reg       <= phase_next;
            wave_sel_reg    <= wave_sel_next;
            playing_reg     <= playing_next;
            m_valid_reg     <= m_valid_next;
            mode_reg        <= mode_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_i_reg    <= cur_i_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvsr_reg     <= dvsr_next;
        res_reg      <= res_next;
        m_sample_reg <= m_sample_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

endmodule
